### rtl/fots_pkg.sv
`default_nettype none

package fots_pkg;

	localparam int unsigned DefTableDepth = 1024;

	localparam int unsigned OFFSET_W = 32;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned COUNT_W  = 11;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_EMPTY = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_entry;  // write table entry, pend a zero result
		logic set_empty;   // pend the empty-table error
		logic start;       // latch query, open search window, issue first probe
		logic step;        // one probe compare
		logic fin;         // neighbour read back, form the shifted offset
		logic publish;     // move pending result into the output register
	} fots_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_lookup;
		logic empty;
		logic hit;
		logic more;
	} fots_stat_t;

endpackage

`default_nettype wire

### rtl/fots_ctrl.sv
`default_nettype none

module fots_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  fots_pkg::fots_stat_t  stat,
	output fots_pkg::fots_cmd_t   cmd
);
	import fots_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load_entry = accept && !stat.op_lookup;
		cmd.set_empty  = accept && stat.op_lookup && stat.empty;
		cmd.start      = accept && stat.op_lookup && !stat.empty;
		cmd.step       = (state_q == S_SRCH);
		cmd.fin        = (state_q == S_FIN);
		cmd.publish    = (state_q == S_DONE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (stat.op_lookup && !stat.empty) ? S_SRCH : S_DONE;
				end
			end
			S_SRCH: begin
				if (stat.hit) begin
					state_d = S_DONE;
				end else if (!stat.more) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_DONE;
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/fots_datapath.sv
`default_nettype none

module fots_datapath #(
	parameter int unsigned TABLE_DEPTH = fots_pkg::DefTableDepth
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	input  wire  [fots_pkg::COUNT_W-1:0]       cfg_data,
	input  fots_pkg::fots_cmd_t                cmd,
	output fots_pkg::fots_stat_t               stat,
	input  wire                                opcode,
	input  wire  [fots_pkg::INDEX_W-1:0]       entry_index,
	input  wire  [fots_pkg::OFFSET_W-1:0]      entry_input_offset,
	input  wire  [fots_pkg::OFFSET_W-1:0]      entry_output_offset,
	input  wire  [fots_pkg::OFFSET_W-1:0]      query_offset,
	output logic [fots_pkg::OFFSET_W-1:0]      result_offset,
	output logic                               exact_match,
	output logic                               status
);
	import fots_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned SW = AW + 2;   // signed window bounds, hi may go to -1
	localparam logic signed [SW-1:0] OneS = 1;

	logic [2*OFFSET_W-1:0] mem [TABLE_DEPTH];
	logic [2*OFFSET_W-1:0] rd_data_q;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic                  wr_ok;
	logic [31:0]           idx32;

	logic [COUNT_W-1:0]    entry_count_q;
	logic [31:0]           cnt32;
	logic [31:0]           n32;
	logic signed [SW-1:0]  n_s;
	logic signed [SW-1:0]  nm1;
	logic [AW-1:0]         mid0;

	logic [OFFSET_W-1:0]   query_q;
	logic signed [SW-1:0]  lo_q, hi_q;
	logic [AW-1:0]         mid_q;
	logic signed [SW-1:0]  mid_s;
	logic signed [SW-1:0]  lo_n, hi_n, sum_n;
	logic [AW-1:0]         mid_n;
	logic [AW-1:0]         sel;
	logic [OFFSET_W-1:0]   rd_in, rd_out;
	logic                  eq, lt, gt;

	logic [OFFSET_W-1:0]   pend_offset_q;
	logic                  pend_exact_q;
	logic                  pend_status_q;

	// table write/read
	assign idx32   = 32'(entry_index);
	assign wr_addr = idx32[AW-1:0];
	assign wr_ok   = idx32 < 32'(TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.load_entry && wr_ok) begin
			mem[wr_addr] <= {entry_input_offset, entry_output_offset};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_in  = rd_data_q[2*OFFSET_W-1:OFFSET_W];
	assign rd_out = rd_data_q[OFFSET_W-1:0];

	// count register, saturated to depth on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	assign cnt32 = 32'(entry_count_q);
	assign n32   = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
	assign n_s   = signed'(n32[SW-1:0]);
	assign nm1   = n_s - OneS;
	assign mid0  = nm1[AW:1];

	// probe compare and next window
	assign mid_s = signed'({2'b00, mid_q});
	assign eq    = (query_q == rd_in);
	assign lt    = (query_q < rd_in);
	assign gt    = !eq && !lt;
	assign lo_n  = lt ? lo_q : (mid_s + OneS);
	assign hi_n  = lt ? (mid_s - OneS) : hi_q;
	assign sum_n = lo_n + hi_n;
	assign mid_n = sum_n[AW:1];
	assign sel   = ((mid_q == '0) || gt) ? mid_q : (mid_q - AW'(1));

	always_comb begin
		stat           = '0;
		stat.op_lookup = (opcode == OP_LOOKUP);
		stat.empty     = (entry_count_q == '0);
		stat.hit       = eq;
		stat.more      = (lo_n <= hi_n);
	end

	always_comb begin
		if (cmd.start) begin
			rd_addr = mid0;
		end else if (stat.more) begin
			rd_addr = mid_n;
		end else begin
			rd_addr = sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			query_q <= query_offset;
			lo_q    <= '0;
			hi_q    <= nm1;
			mid_q   <= mid0;
		end else if (cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.load_entry) begin
			pend_offset_q <= '0;
			pend_exact_q  <= 1'b0;
			pend_status_q <= STAT_OK;
		end else if (cmd.set_empty) begin
			pend_offset_q <= '0;
			pend_exact_q  <= 1'b0;
			pend_status_q <= STAT_EMPTY;
		end else if (cmd.step && eq) begin
			pend_offset_q <= rd_out;
			pend_exact_q  <= 1'b1;
			pend_status_q <= STAT_OK;
		end else if (cmd.fin) begin
			pend_offset_q <= rd_out + (query_q - rd_in);
			pend_exact_q  <= 1'b0;
			pend_status_q <= STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			result_offset <= pend_offset_q;
			exact_match   <= pend_exact_q;
			status        <= pend_status_q;
		end
	end

endmodule

`default_nettype wire

### rtl/fine_offset_translate_search_unit.sv
`default_nettype none
// Fine offset translator: sorted table of (input offset, output offset) pairs.
// Input channel (in_valid/in_ready): opcode 0 loads one entry at entry_index,
// opcode 1 looks up query_offset. Each beat yields exactly one result beat on
// the output channel (out_valid/out_ready): result_offset, exact_match, status.
// Config channel (cfg_valid/cfg_ready, always ready) sets entry_count; write it
// only while the block is idle.
// A load or an empty-table lookup pends its result when the input beat is taken
// and then publishes it. A lookup binary-searches with one table probe per cycle (read
// address for the next probe is formed from the current compare); a miss then
// reads back the neighbour entry to form the shifted offset, an exact hit needs
// no neighbour read. Probes <= floor(log2(n)) + 1, so at most 11 for 1024 entries.
// One item at a time: the next input beat is taken once the current result
// has moved into the output register.
// The output register decouples the sides: a new item is accepted and worked
// on while a finished result waits; a second finished result waits in the
// datapath's pending registers until out_ready frees the register.
// Reset clears the controller, out_valid and entry_count. The table has no
// reset; entries read must have been loaded first.

module fine_offset_translate_search_unit #(
	parameter int unsigned TABLE_DEPTH = fots_pkg::DefTableDepth
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [fots_pkg::COUNT_W-1:0]   cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            opcode,
	input  wire  [fots_pkg::INDEX_W-1:0]   entry_index,
	input  wire  [fots_pkg::OFFSET_W-1:0]  entry_input_offset,
	input  wire  [fots_pkg::OFFSET_W-1:0]  entry_output_offset,
	input  wire  [fots_pkg::OFFSET_W-1:0]  query_offset,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [fots_pkg::OFFSET_W-1:0]  result_offset,
	output logic                           exact_match,
	output logic                           status
);
	import fots_pkg::*;

	fots_cmd_t  cmd;
	fots_stat_t stat;

	// count register takes a beat on any cycle
	assign cfg_ready = 1'b1;

	fots_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fots_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid && cfg_ready),
		.cfg_data            (cfg_data),
		.cmd                 (cmd),
		.stat                (stat),
		.opcode              (opcode),
		.entry_index         (entry_index),
		.entry_input_offset  (entry_input_offset),
		.entry_output_offset (entry_output_offset),
		.query_offset        (query_offset),
		.result_offset       (result_offset),
		.exact_match         (exact_match),
		.status              (status)
	);

endmodule

`default_nettype wire

### rtl/fots_checker.sv
`default_nettype none

module fots_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire [fots_pkg::OFFSET_W-1:0]  result_offset,
	input wire                           exact_match,
	input wire                           status
);
	import fots_pkg::*;

	// beats taken but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_offset)
		&& $stable(exact_match) && $stable(status))
		else $error("result beat changed while stalled");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_EMPTY) |-> (result_offset == '0) && !exact_match)
		else $error("empty-table result carries data");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result beat without an input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two items in the block");

endmodule

bind fine_offset_translate_search_unit fots_checker u_fots_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.result_offset (result_offset),
	.exact_match   (exact_match),
	.status        (status)
);

`default_nettype wire
